>>> src/tatsc_pkg.sv
// Shared types, constants and codes for the two-axis tracker step commander.
`timescale 1ns / 1ps

package tatsc_pkg;

  // Angle constants in 1/256 degree units.
  localparam int unsigned HalfTurn   = 46080;
  localparam int unsigned FullTurn   = 92160;
  localparam int unsigned RightAngle = 23040;

  // Register reset values.
  localparam int unsigned AnglePerPulseReset = 256;
  localparam int unsigned LimitReset         = 4096;

  // Serial divider size: one quotient bit per cycle.
  localparam int unsigned DivBits = 17;
  localparam int unsigned DivCntW = $clog2(DivBits);

  // Configuration register indexes.
  localparam logic [1:0] CFG_ANGLE_PER_PULSE = 2'd0;
  localparam logic [1:0] CFG_AZ_LIMIT        = 2'd1;
  localparam logic [1:0] CFG_ZE_LIMIT        = 2'd2;

  // Command codes.
  localparam logic [2:0] FUNC_TRACK  = 3'd0;
  localparam logic [2:0] FUNC_HOME   = 3'd1;
  localparam logic [2:0] FUNC_JOG_AZ = 3'd2;
  localparam logic [2:0] FUNC_JOG_ZE = 3'd3;
  localparam logic [2:0] FUNC_RAW_AZ = 3'd4;
  localparam logic [2:0] FUNC_RAW_ZE = 3'd5;

  // Axis and direction codes.
  localparam logic AXIS_AZ = 1'b0;
  localparam logic AXIS_ZE = 1'b1;
  localparam logic DIR_CW  = 1'b0;
  localparam logic DIR_CCW = 1'b1;

  // Move planner operations, one per request.
  localparam logic [3:0] OP_NOP      = 4'd0;
  localparam logic [3:0] OP_ZE_HOME  = 4'd1;
  localparam logic [3:0] OP_AZ_HOME  = 4'd2;
  localparam logic [3:0] OP_ZE_TRACK = 4'd3;
  localparam logic [3:0] OP_AZ_TRACK = 4'd4;
  localparam logic [3:0] OP_AZ_JOG   = 4'd5;
  localparam logic [3:0] OP_ZE_JOG   = 4'd6;
  localparam logic [3:0] OP_RAW_AZ   = 4'd7;
  localparam logic [3:0] OP_RAW_ZE   = 4'd8;

  // Working width for position arithmetic with headroom for limits and jogs.
  typedef logic signed [19:0] wide_t;

  // One planned move and the positions after it.
  typedef struct packed {
    logic        axis;
    logic        dir;
    logic [17:0] cnt;
    logic [17:0] az_pos;
    logic [17:0] ze_pos;
  } plan_t;

endpackage

>>> src/two_axis_tracker_step_commander.sv
// Top level: command sequencer, position registers and result register.
`timescale 1ns / 1ps

// Two-axis sun tracker step commander. Each command on the slave stream
// (kind in tuser) yields one or two move requests on the master stream;
// tlast marks the final request of a command. Track and home yield a zenith
// request then an azimuth request; jog, raw and unknown commands yield one.
// The input is ready only while the sequencer is idle. A daytime track
// command runs two divisions back to back on one shared serial divider that
// makes one quotient bit per cycle. The next command can be taken only after
// the load, both divisions with the hand-over between them and the requests;
// a command without divisions needs only the load and its requests. Any
// stall on the master side delays this further. A finished request waits in the
// output register while the next command is taken. Configuration writes are
// always ready and should only be issued while no command is in flight.
module two_axis_tracker_step_commander
  import tatsc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write channel.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [16:0]  cfg_data_i,
  // Command stream.
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata from bit 0: azimuth_angle[16:0], zenith_angle[32:17], time_now[49:33],
  // sunrise_time[66:50], sunset_time[83:67], jog_pulses[101:84], zero pad.
  input  logic [103:0] s_axis_tdata_i,
  // tuser: func[2:0].
  input  logic [2:0]   s_axis_tuser_i,
  // Move request stream.
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata from bit 0: move_dir[0], pulse_count[18:1], az_position[36:19],
  // ze_position[54:37], zero pad.
  output logic [55:0]  m_axis_tdata_o,
  // tuser: move_axis[0].
  output logic         m_axis_tuser_o,
  output logic         m_axis_tlast_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV_ZE = 2'd1;
  localparam logic [1:0] ST_DIV_AZ = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [3:0]         op_q, op_d;
  logic [3:0]         op2_q, op2_d;
  logic               two_q, two_d;
  logic [15:0]        app_q;
  logic [16:0]        az_lim_q, ze_lim_q;
  logic signed [17:0] az_pos_q, az_pos_d;
  logic signed [17:0] ze_pos_q, ze_pos_d;
  logic [16:0]        azn_q, azn_d;
  logic               eln_neg_q, eln_neg_d;
  logic signed [17:0] zt_q, zt_d;
  logic [16:0]        at_q, at_d;
  logic signed [17:0] jog_q, jog_d;

  logic               m_valid_q, m_valid_d;
  plan_t              m_plan_q, m_plan_d;
  logic               m_last_q, m_last_d;

  // Input fields.
  logic [2:0]         in_func;
  logic [16:0]        in_az;
  logic [15:0]        in_ze;
  logic [16:0]        in_now, in_rise, in_set;
  logic signed [17:0] in_jog;

  logic               accept;
  logic               night;
  logic [17:0]        azn_full;
  logic signed [17:0] eln;
  logic [16:0]        eln_abs;
  logic               out_free;
  logic               load_out;

  logic               div_start;
  logic [16:0]        div_dividend;
  logic               div_done;
  logic [16:0]        div_quo;
  plan_t              plan;

  assign in_func = s_axis_tuser_i;
  assign in_az   = s_axis_tdata_i[16:0];
  assign in_ze   = s_axis_tdata_i[32:17];
  assign in_now  = s_axis_tdata_i[49:33];
  assign in_rise = s_axis_tdata_i[66:50];
  assign in_set  = s_axis_tdata_i[83:67];
  assign in_jog  = s_axis_tdata_i[101:84];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign night           = (in_now < in_rise) || (in_now > in_set);

  // Angle normalization: azimuth folded about south, elevation from zenith.
  always_comb begin
    if (in_az > 17'(HalfTurn)) begin
      azn_full = 18'(FullTurn + HalfTurn) - {1'b0, in_az};
    end else begin
      azn_full = 18'(HalfTurn) - {1'b0, in_az};
    end
    eln     = $signed(18'(RightAngle)) - $signed({2'b00, in_ze});
    eln_abs = (eln < 0) ? 17'(-eln) : eln[16:0];
  end

  // The divider takes the elevation on accept and the azimuth after it.
  assign div_start    = (accept && in_func == FUNC_TRACK && !night) ||
                        (state_q == ST_DIV_ZE && div_done);
  assign div_dividend = (state_q == ST_IDLE) ? eln_abs : azn_q;

  tatsc_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (app_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  tatsc_move_plan u_move_plan (
    .op_i        (op_q),
    .az_pos_i    (az_pos_q),
    .ze_pos_i    (ze_pos_q),
    .az_lim_i    (az_lim_q),
    .ze_lim_i    (ze_lim_q),
    .ze_target_i (zt_q),
    .az_target_i (at_q),
    .jog_i       (jog_q),
    .plan_o      (plan)
  );

  assign out_free = !m_valid_q || m_axis_tready_i;
  assign load_out = (state_q == ST_EMIT) && out_free;

  // Sequencer: decode the command, run the divisions, then issue requests.
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    op2_d     = op2_q;
    two_d     = two_q;
    azn_d     = azn_q;
    eln_neg_d = eln_neg_q;
    zt_d      = zt_q;
    at_d      = at_q;
    jog_d     = jog_q;
    az_pos_d  = az_pos_q;
    ze_pos_d  = ze_pos_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          jog_d     = in_jog;
          azn_d     = azn_full[16:0];
          eln_neg_d = (eln < 0);
          two_d     = 1'b0;
          op2_d     = OP_NOP;
          state_d   = ST_EMIT;
          case (in_func)
            FUNC_TRACK: begin
              two_d = 1'b1;
              if (night) begin
                op_d  = OP_ZE_HOME;
                op2_d = OP_AZ_HOME;
              end else begin
                op_d    = OP_ZE_TRACK;
                op2_d   = OP_AZ_TRACK;
                state_d = ST_DIV_ZE;
              end
            end
            FUNC_HOME: begin
              two_d = 1'b1;
              op_d  = OP_ZE_HOME;
              op2_d = OP_AZ_HOME;
            end
            FUNC_JOG_AZ: op_d = OP_AZ_JOG;
            FUNC_JOG_ZE: op_d = OP_ZE_JOG;
            FUNC_RAW_AZ: op_d = OP_RAW_AZ;
            FUNC_RAW_ZE: op_d = OP_RAW_ZE;
            default:     op_d = OP_NOP;
          endcase
        end
      end
      ST_DIV_ZE: begin
        // Truncation toward zero: divide the magnitude, restore the sign.
        if (div_done) begin
          zt_d    = eln_neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
          state_d = ST_DIV_AZ;
        end
      end
      ST_DIV_AZ: begin
        if (div_done) begin
          at_d    = div_quo;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          az_pos_d = plan.az_pos;
          ze_pos_d = plan.ze_pos;
          if (two_q) begin
            op_d  = op2_q;
            two_d = 1'b0;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result register between the sequencer and the master side.
  always_comb begin
    m_plan_d  = m_plan_q;
    m_last_d  = m_last_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    if (load_out) begin
      m_plan_d  = plan;
      m_last_d  = !two_q;
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= OP_NOP;
      op2_q     <= OP_NOP;
      two_q     <= 1'b0;
      az_pos_q  <= '0;
      ze_pos_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      op2_q     <= op2_d;
      two_q     <= two_d;
      az_pos_q  <= az_pos_d;
      ze_pos_q  <= ze_pos_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Command operands and result payload.
  always_ff @(posedge clk_i) begin
    azn_q     <= azn_d;
    eln_neg_q <= eln_neg_d;
    zt_q      <= zt_d;
    at_q      <= at_d;
    jog_q     <= jog_d;
    m_plan_q  <= m_plan_d;
    m_last_q  <= m_last_d;
  end

  // Configuration registers; writes beyond the list are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      app_q    <= 16'(AnglePerPulseReset);
      az_lim_q <= 17'(LimitReset);
      ze_lim_q <= 17'(LimitReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ANGLE_PER_PULSE: app_q    <= cfg_data_i[15:0];
        CFG_AZ_LIMIT:        az_lim_q <= cfg_data_i;
        CFG_ZE_LIMIT:        ze_lim_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, m_plan_q.ze_pos, m_plan_q.az_pos, m_plan_q.cnt, m_plan_q.dir};
  assign m_axis_tuser_o  = m_plan_q.axis;
  assign m_axis_tlast_o  = m_last_q;

endmodule

>>> src/tatsc_divider.sv
// Restoring serial divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module tatsc_divider
  import tatsc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DivBits-1:0]   dividend_i,
  input  logic [15:0]          divisor_i,
  output logic                 done_o,
  output logic [DivBits-1:0]   quotient_o
);

  logic               run_q, run_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [15:0]        rem_q, rem_d;
  logic [DivBits-1:0] quo_q, quo_d;
  logic [15:0]        dvs_q, dvs_d;
  logic [16:0]        trial;
  logic [16:0]        diff;
  logic               fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    trial = {rem_q, quo_q[DivBits-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});
  end

  // Control: start loads the operands, then the step repeats DivBits times.
  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      quo_d = dividend_i;
      // A zero step angle counts as one.
      dvs_d = (divisor_i == 16'd0) ? 16'd1 : divisor_i;
    end else if (run_q) begin
      rem_d = fits ? diff[15:0] : trial[15:0];
      quo_d = {quo_q[DivBits-2:0], fits};
      cnt_d = cnt_q + DivCntW'(1);
      if (cnt_q == DivCntW'(DivBits - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> src/tatsc_move_plan.sv
// Move planner: limit checks and position update for one axis request.
`timescale 1ns / 1ps

module tatsc_move_plan
  import tatsc_pkg::*;
(
  input  logic [3:0]         op_i,
  input  logic signed [17:0] az_pos_i,
  input  logic signed [17:0] ze_pos_i,
  input  logic [16:0]        az_lim_i,
  input  logic [16:0]        ze_lim_i,
  input  logic signed [17:0] ze_target_i,
  input  logic [16:0]        az_target_i,
  input  logic signed [17:0] jog_i,
  output plan_t              plan_o
);

  wide_t cur_az, cur_ze, al, zl, zt, at, p, delta, mag, sum, cnt;
  logic  dir;
  logic  axis;
  logic [17:0] az_new, ze_new;

  always_comb begin
    cur_az = {{2{az_pos_i[17]}}, az_pos_i};
    cur_ze = {{2{ze_pos_i[17]}}, ze_pos_i};
    al     = {3'b000, az_lim_i};
    zl     = {3'b000, ze_lim_i};
    zt     = {{2{ze_target_i[17]}}, ze_target_i};
    at     = {3'b000, az_target_i};
    p      = {{2{jog_i[17]}}, jog_i};
    delta  = '0;
    mag    = '0;
    sum    = '0;
    cnt    = '0;
    dir    = DIR_CW;
    axis   = AXIS_AZ;
    az_new = az_pos_i;
    ze_new = ze_pos_i;

    case (op_i)
      // Zenith home only from inside [0, limit].
      OP_ZE_HOME: begin
        axis = AXIS_ZE;
        if (cur_ze <= zl && cur_ze > 0) begin
          cnt    = cur_ze;
          ze_new = '0;
        end
      end
      // Azimuth home only when strictly inside the limit.
      OP_AZ_HOME: begin
        mag = (cur_az < 0) ? -cur_az : cur_az;
        if (cur_az != 0 && mag < al) begin
          dir    = (cur_az < 0) ? DIR_CW : DIR_CCW;
          cnt    = mag;
          az_new = '0;
        end
      end
      // Zenith track; a target below the horizon parks the axis at zero.
      OP_ZE_TRACK: begin
        axis  = AXIS_ZE;
        delta = zt - cur_ze;
        if (cur_ze <= zl && cur_ze >= 0 && delta != 0) begin
          if (zt < 0) begin
            ze_new = '0;
          end else begin
            dir    = (delta > 0) ? DIR_CCW : DIR_CW;
            cnt    = (delta < 0) ? -delta : delta;
            ze_new = zt[17:0];
          end
        end
      end
      // Azimuth track, blocked on the side where the limit is reached.
      OP_AZ_TRACK: begin
        delta = at - cur_az;
        if (delta < 0) begin
          if (cur_az > -al) begin
            dir    = DIR_CCW;
            cnt    = -delta;
            az_new = at[17:0];
          end
        end else if (delta > 0 && cur_az < al) begin
          dir    = DIR_CW;
          cnt    = delta;
          az_new = at[17:0];
        end
      end
      // Azimuth jog clamped to the symmetric limit.
      OP_AZ_JOG: begin
        sum = cur_az + p;
        if (p < 0 && cur_az > -al) begin
          if (sum < -al) begin
            sum = -al;
          end
          cnt    = cur_az - sum;
          dir    = DIR_CW;
          az_new = sum[17:0];
        end else if (p > 0 && cur_az < al) begin
          if (sum > al) begin
            sum = al;
          end
          cnt    = sum - cur_az;
          dir    = DIR_CCW;
          az_new = sum[17:0];
        end
      end
      // Zenith jog clamped to [0, limit].
      OP_ZE_JOG: begin
        axis = AXIS_ZE;
        sum  = cur_ze + p;
        if (p > 0 && cur_ze < zl) begin
          if (sum > zl) begin
            sum = zl;
          end
          cnt    = sum - cur_ze;
          dir    = DIR_CCW;
          ze_new = sum[17:0];
        end else if (p < 0 && cur_ze > 0) begin
          if (sum < 0) begin
            sum = '0;
          end
          cnt    = cur_ze - sum;
          dir    = DIR_CW;
          ze_new = sum[17:0];
        end
      end
      // Raw moves leave the stored positions alone.
      OP_RAW_AZ, OP_RAW_ZE: begin
        axis = (op_i == OP_RAW_ZE) ? AXIS_ZE : AXIS_AZ;
        dir  = (p < 0) ? DIR_CW : DIR_CCW;
        cnt  = (p < 0) ? -p : p;
      end
      default: begin
      end
    endcase

    // A request without pulses always reports clockwise.
    if (cnt == 0) begin
      dir = DIR_CW;
    end

    plan_o.axis   = axis;
    plan_o.dir    = dir;
    plan_o.cnt    = cnt[17:0];
    plan_o.az_pos = az_new;
    plan_o.ze_pos = ze_new;
  end

endmodule

>>> verif/two_axis_tracker_step_commander_tb.sv
// Self-checking testbench for the two-axis tracker step commander.
`timescale 1ns / 1ps

module two_axis_tracker_step_commander_tb;
  import tatsc_pkg::*;

  // Command codes that the block does not define.
  localparam logic [2:0] FuncSpare6 = 3'd6;
  localparam logic [2:0] FuncSpare7 = 3'd7;

  // Cycles allowed for a command in flight before the registers are touched.
  localparam int unsigned SettleCycles = 60;
  // Length of the long output stall.
  localparam int unsigned HoldCycles = 400;

  // One command as offered on the command stream, with the gap before it.
  typedef struct {
    logic [2:0]         func;
    logic [16:0]        az_angle;
    logic [15:0]        ze_angle;
    logic [16:0]        t_now;
    logic [16:0]        t_rise;
    logic [16:0]        t_set;
    logic signed [17:0] jog;
    int unsigned        pause;
  } command_t;

  // One move request as it should leave the block.
  typedef struct {
    logic        axis;
    logic        dir;
    logic [17:0] cnt;
    logic [17:0] az_pos;
    logic [17:0] ze_pos;
    logic        last;
  } move_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = CFG_ANGLE_PER_PULSE;
  logic [16:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic [2:0]   s_tuser = FUNC_TRACK;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [55:0]  m_tdata;
  logic         m_tuser;
  logic         m_tlast;

  // Shadow of the block: registers and step positions.
  longint pulse_angle = AnglePerPulseReset;
  longint az_limit = LimitReset;
  longint ze_limit = LimitReset;
  longint az_pos = 0;
  longint ze_pos = 0;

  command_t pending_cmds[$];
  move_t    expected_moves[$];

  // Command sender state.
  command_t    cur_cmd = '{default: 0};
  logic        send_busy = 1'b0;
  int unsigned send_wait = 0;
  logic        cmd_taken = 1'b0;
  logic        tx_idle_on = 1'b1;

  // Move receiver state.
  int unsigned rx_stall = 0;
  logic        move_taken = 1'b0;
  logic        rx_idle_on = 1'b1;
  logic        hold_go = 1'b0;
  logic        hold_used = 1'b0;
  int unsigned hold_left = 0;

  int mismatches = 0;
  int moves_seen = 0;
  int func_count[8] = '{default: 0};

  two_axis_tracker_step_commander uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [17:0] got, logic [17:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0d (0x%h), expected %0d (0x%h)",
                                name, got, got, want, want));
    end
  endtask

  function automatic longint wrap18(longint v);
    return longint'($signed(v[17:0]));
  endfunction

  // Queue one move request; a request without pulses always reads clockwise.
  task automatic emit_move(logic axis, logic dir, longint cnt, logic last);
    move_t m;
    if (cnt <= 0) begin
      cnt = 0;
      dir = DIR_CW;
    end
    m.axis   = axis;
    m.dir    = dir;
    m.cnt    = cnt[17:0];
    m.az_pos = az_pos[17:0];
    m.ze_pos = ze_pos[17:0];
    m.last   = last;
    expected_moves.push_back(m);
  endtask

  // Zenith homes only from inside its travel range.
  task automatic home_zenith(logic last);
    longint cnt;
    cnt = 0;
    if (ze_pos <= ze_limit && ze_pos > 0) begin
      cnt = ze_pos;
      ze_pos = 0;
    end
    emit_move(AXIS_ZE, DIR_CW, cnt, last);
  endtask

  // Azimuth is left alone at or beyond its limit.
  task automatic home_azimuth(logic last);
    longint mag;
    longint cnt;
    logic   dir;
    mag = az_pos < 0 ? -az_pos : az_pos;
    dir = DIR_CW;
    cnt = 0;
    if (az_pos != 0 && mag < az_limit) begin
      dir = az_pos < 0 ? DIR_CW : DIR_CCW;
      cnt = mag;
      az_pos = 0;
    end
    emit_move(AXIS_AZ, dir, cnt, last);
  endtask

  // A target below the horizon parks the zenith at zero without a move.
  task automatic track_zenith(longint target);
    longint delta;
    longint mag;
    longint cnt;
    logic   dir;
    delta = target - ze_pos;
    mag = delta < 0 ? -delta : delta;
    dir = DIR_CW;
    cnt = 0;
    if (ze_pos <= ze_limit && ze_pos >= 0 && mag > 0) begin
      if (target < 0) begin
        target = 0;
      end else begin
        dir = delta > 0 ? DIR_CCW : DIR_CW;
        cnt = mag;
      end
      ze_pos = wrap18(target);
    end
    emit_move(AXIS_ZE, dir, cnt, 1'b0);
  endtask

  // The limit only gates the start of an azimuth move, not its target.
  task automatic track_azimuth(longint target);
    longint delta;
    longint cnt;
    logic   dir;
    delta = target - az_pos;
    dir = DIR_CW;
    cnt = 0;
    if (delta < 0) begin
      if (az_pos > -az_limit) begin
        dir = DIR_CCW;
        cnt = -delta;
        az_pos = wrap18(target);
      end
    end else if (delta > 0 && az_pos < az_limit) begin
      dir = DIR_CW;
      cnt = delta;
      az_pos = wrap18(target);
    end
    emit_move(AXIS_AZ, dir, cnt, 1'b1);
  endtask

  task automatic jog_azimuth(longint p);
    longint cnt;
    logic   dir;
    dir = DIR_CW;
    cnt = 0;
    if (p < 0 && az_pos > -az_limit) begin
      if (az_pos + p < -az_limit) p = -az_limit - az_pos;
      cnt = -p;
      dir = DIR_CW;
      az_pos = wrap18(az_pos + p);
    end else if (p > 0 && az_pos < az_limit) begin
      if (az_pos + p > az_limit) p = az_limit - az_pos;
      cnt = p;
      dir = DIR_CCW;
      az_pos = wrap18(az_pos + p);
    end
    emit_move(AXIS_AZ, dir, cnt, 1'b1);
  endtask

  task automatic jog_zenith(longint p);
    longint cnt;
    logic   dir;
    dir = DIR_CW;
    cnt = 0;
    if (p > 0 && ze_pos < ze_limit) begin
      if (ze_pos + p > ze_limit) p = ze_limit - ze_pos;
      cnt = p;
      dir = DIR_CCW;
      ze_pos = wrap18(ze_pos + p);
    end else if (p < 0 && ze_pos > 0) begin
      if (ze_pos + p < 0) p = -ze_pos;
      cnt = -p;
      dir = DIR_CW;
      ze_pos = wrap18(ze_pos + p);
    end
    emit_move(AXIS_ZE, dir, cnt, 1'b1);
  endtask

  // Work out the move requests that one accepted command causes.
  task automatic plan_command(command_t c);
    longint az;
    longint ze;
    longint jog;
    longint divisor;
    longint half_turn;
    longint full_turn;
    longint right_angle;
    longint az_norm;
    longint el_norm;
    az = c.az_angle;
    ze = c.ze_angle;
    jog = c.jog;
    half_turn = HalfTurn;
    full_turn = FullTurn;
    right_angle = RightAngle;
    divisor = pulse_angle == 0 ? 1 : pulse_angle;
    case (c.func)
      FUNC_TRACK: begin
        if (c.t_now < c.t_rise || c.t_now > c.t_set) begin
          home_zenith(1'b0);
          home_azimuth(1'b1);
        end else begin
          az_norm = (az > half_turn ? full_turn - az : -az) + half_turn;
          el_norm = right_angle - ze;
          track_zenith(el_norm / divisor);
          track_azimuth(az_norm / divisor);
        end
      end
      FUNC_HOME: begin
        home_zenith(1'b0);
        home_azimuth(1'b1);
      end
      FUNC_JOG_AZ: jog_azimuth(jog);
      FUNC_JOG_ZE: jog_zenith(jog);
      FUNC_RAW_AZ, FUNC_RAW_ZE: begin
        emit_move(c.func == FUNC_RAW_AZ ? AXIS_AZ : AXIS_ZE, jog < 0 ? DIR_CW : DIR_CCW,
                  jog < 0 ? -jog : jog, 1'b1);
      end
      default: emit_move(AXIS_AZ, DIR_CW, 0, 1'b1);
    endcase
  endtask

  function automatic int unsigned draw_pause();
    if (!tx_idle_on || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  function automatic command_t make_cmd(logic [2:0] f, int az, int ze, int tn, int tr, int ts,
                                        int jog);
    command_t c;
    c.func     = f;
    c.az_angle = az[16:0];
    c.ze_angle = ze[15:0];
    c.t_now    = tn[16:0];
    c.t_rise   = tr[16:0];
    c.t_set    = ts[16:0];
    c.jog      = jog[17:0];
    c.pause    = draw_pause();
    return c;
  endfunction

  // Tracking most often, by day or night, with jogs, homing, raw moves and undefined codes mixed in.
  function automatic command_t random_cmd();
    int pick;
    int t0;
    int t1;
    int t2;
    int lo;
    int hi;
    int mid;
    int jog;
    int tn;
    int tr;
    int ts;
    logic [2:0] f;
    pick = $urandom_range(0, 99);
    t0 = $urandom_range(0, 86399);
    t1 = $urandom_range(0, 86399);
    t2 = $urandom_range(0, 86399);
    lo = t0 < t1 ? (t0 < t2 ? t0 : t2) : (t1 < t2 ? t1 : t2);
    hi = t0 > t1 ? (t0 > t2 ? t0 : t2) : (t1 > t2 ? t1 : t2);
    mid = t0 + t1 + t2 - lo - hi;
    tn = mid;
    tr = lo;
    ts = hi;
    if ($urandom_range(0, 4) == 0) begin
      // Night: either before sunrise or after sunset.
      if ($urandom_range(0, 1) == 0) begin
        tn = lo;
        tr = mid;
      end else begin
        tn = hi;
        ts = mid;
      end
    end
    if ($urandom_range(0, 2) == 0) jog = int'($urandom_range(0, 262142)) - 131071;
    else jog = int'($urandom_range(0, 6000)) - 3000;
    if (pick < 45) f = FUNC_TRACK;
    else if (pick < 53) f = FUNC_HOME;
    else if (pick < 68) f = FUNC_JOG_AZ;
    else if (pick < 83) f = FUNC_JOG_ZE;
    else if (pick < 93) f = $urandom_range(0, 1) == 0 ? FUNC_RAW_AZ : FUNC_RAW_ZE;
    else f = $urandom_range(0, 1) == 0 ? FuncSpare6 : FuncSpare7;
    return make_cmd(f, $urandom_range(0, 92159), $urandom_range(0, 46080), tn, tr, ts, jog);
  endfunction

  task automatic queue_random(int n);
    repeat (n) pending_cmds.push_back(random_cmd());
  endtask

  // Wait until every command has been taken and every request has come out.
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || send_busy || expected_moves.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] value);
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(int angle, int az_lim, int ze_lim);
    write_reg(CFG_ANGLE_PER_PULSE, angle[16:0]);
    write_reg(CFG_AZ_LIMIT, az_lim[16:0]);
    write_reg(CFG_ZE_LIMIT, ze_lim[16:0]);
  endtask

  // Command sender: waits out each command's gap, then holds it until taken.
  always @(negedge clk_i) begin
    if (cmd_taken) send_busy = 1'b0;
    if (!send_busy && pending_cmds.size() != 0) begin
      if (send_wait < pending_cmds[0].pause) begin
        send_wait++;
      end else begin
        cur_cmd = pending_cmds.pop_front();
        send_busy = 1'b1;
        send_wait = 0;
      end
    end
    s_tvalid <= send_busy;
    s_tuser  <= cur_cmd.func;
    s_tdata  <= {2'b00, cur_cmd.jog, cur_cmd.t_set, cur_cmd.t_rise, cur_cmd.t_now,
                 cur_cmd.ze_angle, cur_cmd.az_angle};
  end

  // Move receiver: a random stall after each request, plus the long hold.
  always @(negedge clk_i) begin
    if (move_taken) begin
      rx_stall = (rx_idle_on && $urandom_range(0, 2) != 0) ? $urandom_range(0, 19) : 0;
    end
    m_tready <= (rx_stall == 0) && (hold_left == 0);
    if (rx_stall != 0) rx_stall--;
  end

  // One long output stall, counted here while the sender keeps offering.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_used) begin
      hold_left <= HoldCycles;
      hold_used <= 1'b1;
    end
  end

  // Check requests, then track register writes and accepted commands.
  always @(posedge clk_i) begin
    move_t want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        moves_seen++;
        if (expected_moves.size() == 0) begin
          report_mismatch($sformatf("move request with none expected, tdata 0x%h", m_tdata));
        end else begin
          want = expected_moves.pop_front();
          check_field("move_axis", 18'(m_tuser), 18'(want.axis));
          check_field("move_dir", 18'(m_tdata[0]), 18'(want.dir));
          check_field("pulse_count", m_tdata[18:1], want.cnt);
          check_field("az_position", m_tdata[36:19], want.az_pos);
          check_field("ze_position", m_tdata[54:37], want.ze_pos);
          check_field("last", 18'(m_tlast), 18'(want.last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ANGLE_PER_PULSE: pulse_angle = cfg_data[15:0];
          CFG_AZ_LIMIT:        az_limit = cfg_data;
          CFG_ZE_LIMIT:        ze_limit = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        plan_command(cur_cmd);
        func_count[cur_cmd.func]++;
      end
    end
    cmd_taken  <= rst_ni && s_tvalid && s_tready;
    move_taken <= rst_ni && m_tvalid && m_tready;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed commands at the reset register values.
    pending_cmds.push_back(make_cmd(FUNC_TRACK, 0, 0, 43200, 21600, 64800, 0));
    // Sun below the horizon: zenith target under zero.
    pending_cmds.push_back(make_cmd(FUNC_TRACK, 92159, 46080, 43200, 0, 86399, 0));
    // Azimuth exactly at the half turn, time equal to sunrise.
    pending_cmds.push_back(make_cmd(FUNC_TRACK, 46080, 23040, 21600, 21600, 64800, 1));
    // Just past the half turn, time equal to sunset.
    pending_cmds.push_back(make_cmd(FUNC_TRACK, 46081, 1, 64800, 21600, 64800, -1));
    // Night before sunrise and after sunset.
    pending_cmds.push_back(make_cmd(FUNC_TRACK, 30000, 10000, 0, 1, 86399, 0));
    pending_cmds.push_back(make_cmd(FUNC_TRACK, 70000, 2000, 86399, 0, 50000, 0));
    pending_cmds.push_back(make_cmd(FUNC_TRACK, 92159, 0, 40000, 30000, 50000, 0));
    pending_cmds.push_back(make_cmd(FUNC_HOME, 0, 0, 0, 0, 0, 0));
    // Azimuth jogs that clamp at both limits, then push past them.
    pending_cmds.push_back(make_cmd(FUNC_JOG_AZ, 0, 0, 0, 0, 0, 131071));
    pending_cmds.push_back(make_cmd(FUNC_JOG_AZ, 0, 0, 0, 0, 0, 5));
    // Home with the azimuth sitting on its limit.
    pending_cmds.push_back(make_cmd(FUNC_HOME, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_JOG_AZ, 0, 0, 0, 0, 0, -131071));
    pending_cmds.push_back(make_cmd(FUNC_JOG_AZ, 0, 0, 0, 0, 0, -1));
    // Zenith jogs to the top, back to zero and below.
    pending_cmds.push_back(make_cmd(FUNC_JOG_ZE, 0, 0, 0, 0, 0, 131071));
    pending_cmds.push_back(make_cmd(FUNC_JOG_ZE, 0, 0, 0, 0, 0, -131071));
    pending_cmds.push_back(make_cmd(FUNC_JOG_ZE, 0, 0, 0, 0, 0, -5));
    pending_cmds.push_back(make_cmd(FUNC_JOG_ZE, 0, 0, 0, 0, 0, 100));
    // Raw moves, including one with no pulses.
    pending_cmds.push_back(make_cmd(FUNC_RAW_AZ, 0, 0, 0, 0, 0, 131071));
    pending_cmds.push_back(make_cmd(FUNC_RAW_ZE, 0, 0, 0, 0, 0, -131071));
    pending_cmds.push_back(make_cmd(FUNC_RAW_AZ, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FuncSpare6, 92159, 46080, 86399, 86399, 86399, 1));
    pending_cmds.push_back(make_cmd(FuncSpare7, 0, 0, 0, 0, 0, -1));
    wait_idle();

    // Finest pulse angle with the widest travel.
    write_all(1, 131071, 131071);
    queue_random(250);
    wait_idle();

    // Coarsest pulse angle with no travel at all.
    write_all(65535, 0, 0);
    queue_random(200);
    wait_idle();

    // Zero pulse angle behaves as one; narrow limits; one long output stall.
    write_all(0, 100, 50);
    hold_go = 1'b1;
    queue_random(200);
    wait_idle();

    // Random settings; the middle one runs without any idling.
    for (int k = 0; k < 3; k++) begin
      write_all($urandom_range(0, 3) == 0 ? $urandom_range(1, 65535) : $urandom_range(1, 512),
                $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071) : $urandom_range(1, 8000),
                $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071) : $urandom_range(1, 8000));
      tx_idle_on = (k != 1);
      rx_idle_on = (k != 1);
      queue_random(200);
      wait_idle();
    end

    $display("Commands taken: %0d track, %0d home, %0d jog, %0d raw, %0d undefined code.",
             func_count[FUNC_TRACK], func_count[FUNC_HOME],
             func_count[FUNC_JOG_AZ] + func_count[FUNC_JOG_ZE],
             func_count[FUNC_RAW_AZ] + func_count[FUNC_RAW_ZE],
             func_count[FuncSpare6] + func_count[FuncSpare7]);
    $display("Compared %0d move requests across seven register settings, %0d mismatches.",
             moves_seen, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Timed out with %0d requests still expected.", expected_moves.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
src/tatsc_pkg.sv
src/tatsc_divider.sv
src/tatsc_move_plan.sv
src/two_axis_tracker_step_commander.sv
verif/two_axis_tracker_step_commander_tb.sv
